>>> src/spfb_pkg.sv
// shared types and constants of the scatter plot frame buffer
package spfb_pkg;

  localparam int unsigned DefPlotWidth  = 256;
  localparam int unsigned DefPlotHeight = 256;

  localparam int unsigned PosW     = 32;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned ColourW  = 3 * ChanW;
  localparam int unsigned PixW     = 8;
  localparam int unsigned FuncW    = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 2 * PosW + ColourW + 2 * PixW;

  // reset values of the configuration registers
  localparam logic [PosW-1:0]    RstXMin   = 32'd0;
  localparam logic [PosW-1:0]    RstXMax   = 32'd16777216;
  localparam logic [PosW-1:0]    RstYMin   = 32'd0;
  localparam logic [PosW-1:0]    RstYMax   = 32'd16777216;
  localparam logic [PosW-1:0]    RstXScale = 32'd65280;
  localparam logic [PosW-1:0]    RstYScale = 32'd65280;
  localparam logic [ColourW-1:0] RstBg     = 24'd0;

  typedef enum logic [FuncW-1:0] {
    FUNC_MARK  = 2'd0,
    FUNC_CROSS = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_OUTSIDE = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_X_MIN   = 3'd0,
    REG_X_MAX   = 3'd1,
    REG_Y_MIN   = 3'd2,
    REG_Y_MAX   = 3'd3,
    REG_X_SCALE = 3'd4,
    REG_Y_SCALE = 3'd5,
    REG_BG      = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MAP,
    ST_MARK,
    ST_VLINE,
    ST_HLINE,
    ST_CLEAR,
    ST_READ,
    ST_RDATA,
    ST_RESP
  } state_e;

  // plot box and scale registers
  typedef struct packed {
    logic [PosW-1:0] x_min;
    logic [PosW-1:0] x_max;
    logic [PosW-1:0] y_min;
    logic [PosW-1:0] y_max;
    logic [PosW-1:0] x_scale;
    logic [PosW-1:0] y_scale;
  } box_cfg_t;

endpackage

>>> src/spfb_map.sv
// three-stage mapping unit: box test, scale multiply, saturation to pixel
module spfb_map import spfb_pkg::*; #(
  parameter int unsigned FB_WIDTH  = DefPlotWidth,
  parameter int unsigned FB_HEIGHT = DefPlotHeight,
  parameter int unsigned COL_W     = $clog2(DefPlotWidth),
  parameter int unsigned ROW_W     = $clog2(DefPlotHeight)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [PosW-1:0]  pos_x_i,
  input  logic [PosW-1:0]  pos_y_i,
  input  box_cfg_t         cfg_i,
  output logic             done_o,
  output logic             inside_o,
  output logic [COL_W-1:0] col_o,
  output logic [ROW_W-1:0] row_o
);

  localparam logic [PosW-1:0]  ColMaxW = PosW'(FB_WIDTH - 1);
  localparam logic [PosW-1:0]  RowMaxW = PosW'(FB_HEIGHT - 1);
  localparam logic [COL_W-1:0] ColMax  = COL_W'(FB_WIDTH - 1);
  localparam logic [ROW_W-1:0] RowMax  = ROW_W'(FB_HEIGHT - 1);

  logic             v1_q, v2_q, v3_q;
  logic             in1_q, in2_q, in3_q;
  logic             in1_d;
  logic [PosW-1:0]  dx_q, dy_q;
  logic [PosW-1:0]  cx_q, cy_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [2*PosW-1:0] prod_x, prod_y;

  // inclusive containment test on signed positions
  always_comb begin
    in1_d = ($signed(pos_x_i) >= $signed(cfg_i.x_min)) &&
            ($signed(pos_x_i) <= $signed(cfg_i.x_max)) &&
            ($signed(pos_y_i) >= $signed(cfg_i.y_min)) &&
            ($signed(pos_y_i) <= $signed(cfg_i.y_max));
  end

  // offset into box times scale, integer part kept
  assign prod_x = (2*PosW)'(dx_q) * (2*PosW)'(cfg_i.x_scale);
  assign prod_y = (2*PosW)'(dy_q) * (2*PosW)'(cfg_i.y_scale);

  // saturate at the last column and row
  always_comb begin
    col_d = (cx_q > ColMaxW) ? ColMax : cx_q[COL_W-1:0];
    row_d = (cy_q > RowMaxW) ? RowMax : cy_q[ROW_W-1:0];
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    in1_q <= in1_d;
    dx_q  <= pos_x_i - cfg_i.x_min;
    dy_q  <= pos_y_i - cfg_i.y_min;
    in2_q <= in1_q;
    cx_q  <= prod_x[2*PosW-1:PosW];
    cy_q  <= prod_y[2*PosW-1:PosW];
    if (v2_q) begin
      in3_q <= in2_q;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign done_o   = v3_q;
  assign inside_o = in3_q;
  assign col_o    = col_q;
  assign row_o    = row_q;

endmodule

>>> src/spfb_mem.sv
// frame store: one write port, one registered read port
module spfb_mem import spfb_pkg::*; #(
  parameter int unsigned DEPTH  = DefPlotWidth * DefPlotHeight,
  parameter int unsigned ADDR_W = $clog2(DefPlotWidth * DefPlotHeight)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  waddr_i,
  input  logic [ColourW-1:0] wdata_i,
  input  logic               re_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  output logic [ColourW-1:0] rdata_o
);

  logic [ColourW-1:0] mem_q [DEPTH];
  logic [ColourW-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/scatter_plot_framebuffer_top.sv
// scatter plot frame buffer top level: config, sequencer, output register
// mark: result after the mapping unit, one write and the response; no write outside the box
// crosshair: whole mapped column, then whole mapped row, one frame store write per line pixel
// read: result taken from the registered memory read; range status for an off-plot pixel
// clear: background written to every pixel; one item at a time, next accepted after response
// reset: registers to defaults, then a raster sweep zeroing the store,
// no item accepted meanwhile; configuration writes are taken throughout
module scatter_plot_framebuffer_top import spfb_pkg::*; #(
  parameter int unsigned FB_WIDTH  = DefPlotWidth,
  parameter int unsigned FB_HEIGHT = DefPlotHeight
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pos_x, pos_y, colour_red, colour_green, colour_blue, pixel_col, pixel_row
  input  logic [InDataW-1:0]  s_axis_tdata,
  // func
  input  logic [FuncW-1:0]    s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // read_red, read_green, read_blue
  output logic [ColourW-1:0]  m_axis_tdata,
  // status
  output logic [StatusW-1:0]  m_axis_tuser,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned COL_W  = $clog2(FB_WIDTH);
  localparam int unsigned ROW_W  = $clog2(FB_HEIGHT);
  localparam int unsigned ADDR_W = COL_W + ROW_W;
  localparam int unsigned DEPTH  = FB_HEIGHT * (2 ** COL_W);
  localparam logic [COL_W-1:0] ColLast = COL_W'(FB_WIDTH - 1);
  localparam logic [ROW_W-1:0] RowLast = ROW_W'(FB_HEIGHT - 1);
  localparam logic [PosW-1:0]  WidthW  = PosW'(FB_WIDTH);
  localparam logic [PosW-1:0]  HeightW = PosW'(FB_HEIGHT);

  box_cfg_t           cfg_q;
  logic [ColourW-1:0] bg_q;

  state_e             state_q, state_d;
  func_e              func_q, in_func;
  logic [ColourW-1:0] colour_q;
  logic [PixW-1:0]    pix_col_q, pix_row_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  status_e            res_status_q, res_status_d;
  logic [ColourW-1:0] res_rgb_q, res_rgb_d;
  logic               out_valid_q, out_valid_d;
  logic [ColourW-1:0] out_rgb_q;
  status_e            out_status_q;

  logic               accept, out_load;
  logic               col_last, row_last, in_range;
  logic               map_start, map_done, map_inside;
  logic [COL_W-1:0]   map_col;
  logic [ROW_W-1:0]   map_row;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [ColourW-1:0] mem_wdata, mem_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_min   <= RstXMin;
      cfg_q.x_max   <= RstXMax;
      cfg_q.y_min   <= RstYMin;
      cfg_q.y_max   <= RstYMax;
      cfg_q.x_scale <= RstXScale;
      cfg_q.y_scale <= RstYScale;
      bg_q          <= RstBg;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_X_MIN:   cfg_q.x_min   <= cfg_wdata_i;
        REG_X_MAX:   cfg_q.x_max   <= cfg_wdata_i;
        REG_Y_MIN:   cfg_q.y_min   <= cfg_wdata_i;
        REG_Y_MAX:   cfg_q.y_max   <= cfg_wdata_i;
        REG_X_SCALE: cfg_q.x_scale <= cfg_wdata_i;
        REG_Y_SCALE: cfg_q.y_scale <= cfg_wdata_i;
        REG_BG:      bg_q          <= cfg_wdata_i[ColourW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_func       = func_e'(s_axis_tuser);
  assign col_last      = (col_q == ColLast);
  assign row_last      = (row_q == RowLast);
  assign in_range      = ({{(PosW-PixW){1'b0}}, pix_col_q} < WidthW) &&
                         ({{(PosW-PixW){1'b0}}, pix_row_q} < HeightW);
  assign out_load      = (state_q == ST_RESP) && (!out_valid_q || m_axis_tready);

  // position to pixel mapping
  spfb_map #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT),
    .COL_W     (COL_W),
    .ROW_W     (ROW_W)
  ) u_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (map_start),
    .pos_x_i  (s_axis_tdata[PosW-1:0]),
    .pos_y_i  (s_axis_tdata[2*PosW-1:PosW]),
    .cfg_i    (cfg_q),
    .done_o   (map_done),
    .inside_o (map_inside),
    .col_o    (map_col),
    .row_o    (map_row)
  );

  // frame store
  spfb_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        if (col_last && row_last) begin
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_RESP;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FUNC_MARK, FUNC_CROSS: state_d = ST_MAP;
            FUNC_READ:             state_d = ST_READ;
            FUNC_CLEAR:            state_d = ST_CLEAR;
            default:               state_d = ST_IDLE;
          endcase
        end
      end
      ST_MAP: begin
        if (map_done) begin
          if (!map_inside) begin
            state_d = ST_RESP;
          end else if (func_q == FUNC_MARK) begin
            state_d = ST_MARK;
          end else begin
            state_d = ST_VLINE;
          end
        end
      end
      ST_MARK:  state_d = ST_RESP;
      ST_VLINE: begin
        if (row_last) begin
          state_d = ST_HLINE;
        end
      end
      ST_HLINE: begin
        if (col_last) begin
          state_d = ST_RESP;
        end
      end
      ST_READ:  state_d = in_range ? ST_RDATA : ST_RESP;
      ST_RDATA: state_d = ST_RESP;
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_INIT;
    endcase
  end

  // datapath control per state
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = {row_q, col_q};
    mem_wdata    = colour_q;
    mem_re       = 1'b0;
    mem_raddr    = {ROW_W'(pix_row_q), COL_W'(pix_col_q)};
    map_start    = 1'b0;
    col_d        = col_q;
    row_d        = row_q;
    res_status_d = res_status_q;
    res_rgb_d    = res_rgb_q;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        // raster sweep over every pixel
        mem_we    = 1'b1;
        mem_wdata = (state_q == ST_CLEAR) ? bg_q : '0;
        col_d     = col_last ? '0 : col_q + 1'b1;
        if (col_last) begin
          row_d = row_last ? '0 : row_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res_status_d = STATUS_DONE;
          res_rgb_d    = '0;
          map_start    = (in_func == FUNC_MARK) || (in_func == FUNC_CROSS);
        end
      end
      ST_MAP: begin
        if (map_done && !map_inside) begin
          res_status_d = STATUS_OUTSIDE;
        end
      end
      ST_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = {map_row, map_col};
      end
      ST_VLINE: begin
        // whole mapped column
        mem_we    = 1'b1;
        mem_waddr = {row_q, map_col};
        row_d     = row_last ? '0 : row_q + 1'b1;
      end
      ST_HLINE: begin
        // whole mapped row
        mem_we    = 1'b1;
        mem_waddr = {map_row, col_q};
        col_d     = col_last ? '0 : col_q + 1'b1;
      end
      ST_READ: begin
        if (in_range) begin
          mem_re = 1'b1;
        end else begin
          res_status_d = STATUS_RANGE;
        end
      end
      ST_RDATA: res_rgb_d = mem_rdata;
      ST_RESP:  ;
      default:  ;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      col_q        <= '0;
      row_q        <= '0;
      out_valid_q  <= 1'b0;
      res_status_q <= STATUS_DONE;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      row_q        <= row_d;
      out_valid_q  <= out_valid_d;
      res_status_q <= res_status_d;
    end
  end

  // item and result payload, colour held as packed rgb with red on top
  always_ff @(posedge clk_i) begin
    res_rgb_q <= res_rgb_d;
    if (accept) begin
      func_q    <= in_func;
      colour_q  <= {s_axis_tdata[2*PosW +: ChanW], s_axis_tdata[2*PosW+ChanW +: ChanW],
                    s_axis_tdata[2*PosW+2*ChanW +: ChanW]};
      pix_col_q <= s_axis_tdata[2*PosW+ColourW +: PixW];
      pix_row_q <= s_axis_tdata[2*PosW+ColourW+PixW +: PixW];
    end
    if (out_load) begin
      out_rgb_q    <= res_rgb_q;
      out_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_rgb_q[ChanW-1:0], out_rgb_q[2*ChanW-1:ChanW],
                          out_rgb_q[ColourW-1:2*ChanW]};
  assign m_axis_tuser  = out_status_q;

  // the store is written only by the drawing, clearing and reset sweep states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_INIT || state_q == ST_CLEAR || state_q == ST_MARK ||
                state_q == ST_VLINE || state_q == ST_HLINE))
    else $error("frame store written outside a drawing state");

  // a new result appears only from the response state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_RESP)
    else $error("result presented without a response");

  // the mapping unit only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_done |-> state_q == ST_MAP)
    else $error("mapping finished outside the map state");

  // sweep counters are back at the origin whenever an item can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (col_q == '0 && row_q == '0))
    else $error("sweep counters not at origin when idle");

endmodule
